[hw/rtl/esbp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esbp_pkg: shared types and constants
// Byte codes, slot geometry and the command that travels from front to back.
// ----------------------------------------------------------------------------
package esbp_pkg;

    localparam int SLOT_COUNT = 64;
    localparam int SLOT_W     = 6;
    localparam int DATA_W     = 64;
    localparam int TOP_SHIFT  = 56;

    localparam logic [7:0] ESC_BYTE  = 8'h1B;
    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] BAR_BYTE  = 8'h7C;

    // register index, taken from paddr[2]
    localparam logic REG_STAR_BAR = 1'b0;
    localparam logic REG_DIR      = 1'b1;

    typedef enum logic [1:0] {
        KIND_READ = 2'd0,
        KIND_NONE = 2'd1,
        KIND_LOW  = 2'd2,
        KIND_TOP  = 2'd3
    } t_kind;

    typedef struct packed {
        logic star_bar_enable;
        logic pack_direction;
    } t_cfg;

    typedef struct packed {
        t_kind             kind;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        data;
        logic [1:0]        chan;
        logic [SLOT_W-1:0] pos;
        logic              esc;
    } t_cmd;

endpackage
`default_nettype wire

[hw/rtl/esbp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esbp_if: stream channels
// Input item channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface esbp_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] byte_value;
    logic [5:0] slot_select;

    modport source (output valid, output op, output byte_value, output slot_select,
                    input ready);
    modport sink   (input valid, input op, input byte_value, input slot_select,
                    output ready);
endinterface

interface esbp_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  slot_number;
    logic [63:0] slot_value;
    logic        wrote;
    logic [1:0]  current_channel;
    logic [5:0]  current_position;
    logic        escape_pending;

    modport source (output valid, output slot_number, output slot_value, output wrote,
                    output current_channel, output current_position,
                    output escape_pending, input ready);
    modport sink   (input valid, input slot_number, input slot_value, input wrote,
                    input current_channel, input current_position,
                    input escape_pending, output ready);
endinterface
`default_nettype wire

[hw/rtl/esbp_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esbp_cfg: configuration registers
// APB-style register port holding the star/bar enable and the pack direction.
// ----------------------------------------------------------------------------
module esbp_cfg
    import esbp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    logic r_star_bar;
    logic r_dir;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_star_bar <= 1'b0;
            r_dir      <= 1'b1;
        end else if (w_wr) begin
            case (paddr[2])
                REG_STAR_BAR: r_star_bar <= pwdata[0];
                REG_DIR:      r_dir      <= pwdata[0];
                default:      r_dir      <= r_dir;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_STAR_BAR: prdata = {31'd0, r_star_bar};
            REG_DIR:      prdata = {31'd0, r_dir};
            default:      prdata = 32'd0;
        endcase
    end

    assign o_cfg.star_bar_enable = r_star_bar;
    assign o_cfg.pack_direction  = r_dir;

endmodule
`default_nettype wire

[hw/rtl/esbp_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esbp_front: item classifier
// Accepts items, decodes escape and star/bar bytes, tracks position, channel
// and escape state, and pushes one command per item toward the slot file.
// ----------------------------------------------------------------------------
module esbp_front
    import esbp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    esbp_in_if.sink    i_item,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_q_ready,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic [SLOT_W-1:0] r_pos;
    logic [1:0]        r_chan;
    logic              r_esc;
    logic [SLOT_W-1:0] n_pos;
    logic [1:0]        n_chan;
    logic              n_esc;
    logic              w_star;
    logic              w_bar;
    logic [7:0]        w_b;

    assign i_item.ready = i_q_ready;
    assign o_push       = i_item.valid && i_q_ready;

    assign w_b    = i_item.byte_value;
    assign w_star = i_cfg.star_bar_enable && (w_b == STAR_BYTE);
    assign w_bar  = i_cfg.star_bar_enable && (w_b == BAR_BYTE);

    always_comb begin
        n_pos      = r_pos;
        n_chan     = r_chan;
        n_esc      = r_esc;
        o_cmd.kind = KIND_NONE;
        o_cmd.slot = r_pos;
        o_cmd.data = w_b;
        if (i_item.op) begin
            o_cmd.kind = KIND_READ;
            o_cmd.slot = i_item.slot_select;
        end else if (w_star) begin
            // star always packs at the low end and holds the position
            o_cmd.kind = KIND_LOW;
        end else if (w_bar) begin
            o_cmd.kind = KIND_NONE;
        end else if (r_esc) begin
            n_chan     = w_b[7:6];
            n_pos      = w_b[SLOT_W-1:0];
            n_esc      = 1'b0;
            o_cmd.slot = w_b[SLOT_W-1:0];
        end else if (w_b == ESC_BYTE) begin
            n_esc = 1'b1;
        end else begin
            o_cmd.kind = i_cfg.pack_direction ? KIND_TOP : KIND_LOW;
            n_pos      = r_pos + 1'b1;
            // bump the channel when the position wraps
            if (n_pos == '0) begin
                n_chan = r_chan + 1'b1;
            end
        end
        o_cmd.chan = n_chan;
        o_cmd.pos  = n_pos;
        o_cmd.esc  = n_esc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_chan <= '0;
            r_esc  <= 1'b0;
        end else if (o_push) begin
            r_pos  <= n_pos;
            r_chan <= n_chan;
            r_esc  <= n_esc;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/esbp_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esbp_queue: command queue
// Small FIFO of commands between the classifier and the slot file.
// ----------------------------------------------------------------------------
module esbp_queue
    import esbp_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_ready,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

[hw/rtl/esbp_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esbp_back: slot file executor
// Read-modify-write of the 64 x 64-bit slot file with forwarding between
// consecutive commands, and a registered result stage.
// ----------------------------------------------------------------------------
module esbp_back
    import esbp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_valid,
    input  wire t_cmd i_q_cmd,
    output logic      o_pop,
    esbp_out_if.source o_result
);

    logic [DATA_W-1:0]     r_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_written;
    logic [DATA_W-1:0]     r_mem_q;
    logic                  r_vld_q;
    logic                  r_fwd_hit;
    logic [DATA_W-1:0]     r_fwd_data;
    logic                  r_b_valid;
    t_cmd                  r_b_cmd;
    logic                  r_o_valid;
    logic [SLOT_W-1:0]     r_o_slot;
    logic [DATA_W-1:0]     r_o_value;
    logic                  r_o_wrote;
    logic [1:0]            r_o_chan;
    logic [SLOT_W-1:0]     r_o_pos;
    logic                  r_o_esc;

    logic              w_out_load;
    logic              w_b_adv;
    logic              w_wr;
    logic [DATA_W-1:0] w_old;
    logic [DATA_W-1:0] w_new;

    assign w_out_load = !r_o_valid || o_result.ready;
    assign w_b_adv    = r_b_valid && w_out_load;
    assign o_pop      = i_q_valid && (!r_b_valid || w_b_adv);

    // slot never written since reset reads as zero
    assign w_old = r_fwd_hit ? r_fwd_data : (r_vld_q ? r_mem_q : '0);

    always_comb begin
        w_wr = 1'b0;
        case (r_b_cmd.kind)
            KIND_LOW: begin
                w_new = {w_old[DATA_W-9:0], r_b_cmd.data};
                w_wr  = 1'b1;
            end
            KIND_TOP: begin
                w_new = {r_b_cmd.data, w_old[DATA_W-1:8]};
                w_wr  = 1'b1;
            end
            default: w_new = w_old;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_b_adv && w_wr) begin
            r_mem[r_b_cmd.slot] <= w_new;
        end
        if (o_pop) begin
            r_mem_q    <= r_mem[i_q_cmd.slot];
            r_fwd_data <= w_new;
            r_b_cmd    <= i_q_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_vld_q   <= 1'b0;
            r_fwd_hit <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_b_adv && w_wr) begin
                r_written[r_b_cmd.slot] <= 1'b1;
            end
            if (o_pop) begin
                r_vld_q   <= r_written[i_q_cmd.slot];
                // take the value being written this edge when slots collide
                r_fwd_hit <= w_b_adv && w_wr && (r_b_cmd.slot == i_q_cmd.slot);
                r_b_valid <= 1'b1;
            end else if (w_b_adv) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_b_adv) begin
            r_o_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_adv) begin
            r_o_slot  <= r_b_cmd.slot;
            r_o_value <= w_new;
            r_o_wrote <= w_wr;
            r_o_chan  <= r_b_cmd.chan;
            r_o_pos   <= r_b_cmd.pos;
            r_o_esc   <= r_b_cmd.esc;
        end
    end

    assign o_result.valid            = r_o_valid;
    assign o_result.slot_number      = r_o_slot;
    assign o_result.slot_value       = r_o_value;
    assign o_result.wrote            = r_o_wrote;
    assign o_result.current_channel  = r_o_chan;
    assign o_result.current_position = r_o_pos;
    assign o_result.escape_pending   = r_o_esc;

endmodule
`default_nettype wire

[hw/rtl/escaped_byte_slot_packer_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// escaped_byte_slot_packer_core: escaped byte slot packer
// Packs an escaped byte stream into a file of 64 slots of 64 bits.
// ----------------------------------------------------------------------------
// Use:
//   i_item carries one stream byte (op 0) or a slot read (op 1) per item.
//   o_result returns exactly one result per item, in order: the slot touched,
//   its value after the item, a write flag, and the channel, position and
//   escape state after the item.
//   The APB port (psel..pready) holds star/bar enable at 0x0 and pack
//   direction at 0x4; write them only while no item is in flight.
// Timing:
//   Throughput is one item per cycle while o_result is ready. An accepted item
//   passes through the command queue and the slot file read stage, then the
//   write-back and the result register load together.
//   Back-to-back writes to the same slot are forwarded around the slot file.
// Reset:
//   Synchronous, active low. Position, channel and escape state clear, every
//   slot reads as zero at once (per-slot written flags), registers go to
//   star/bar off and top-end packing. No clearing pass.
// Stall:
//   When o_result is held off, the result register holds, the executor stops
//   and the queue fills; i_item.ready drops once QUEUE_DEPTH commands wait.
// ----------------------------------------------------------------------------
module escaped_byte_slot_packer_core
    import esbp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    esbp_in_if.sink          i_item,
    esbp_out_if.source       o_result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_cfg w_cfg;
    t_cmd w_push_cmd;
    t_cmd w_pop_cmd;
    logic w_push;
    logic w_q_ready;
    logic w_q_valid;
    logic w_pop;

    esbp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    esbp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_cfg     (w_cfg),
        .i_q_ready (w_q_ready),
        .o_push    (w_push),
        .o_cmd     (w_push_cmd)
    );

    esbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_pop_cmd)
    );

    esbp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_cmd   (w_pop_cmd),
        .o_pop     (w_pop),
        .o_result  (o_result)
    );

endmodule
`default_nettype wire

[hw/rtl/esbp_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esbp_checker: port-level checks
// Watches the item and result channels of the slot packer.
// ----------------------------------------------------------------------------
module esbp_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [5:0] i_out_slot,
    input wire logic [63:0] i_out_value,
    input wire logic       i_out_wrote,
    input wire logic [1:0] i_out_chan,
    input wire logic [5:0] i_out_pos,
    input wire logic       i_out_esc
);

    // leaving reset: no result shown, input open
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("result valid or input closed right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_slot)
            && $stable(i_out_value) && $stable(i_out_wrote) && $stable(i_out_chan)
            && $stable(i_out_pos) && $stable(i_out_esc))
        else $error("stalled result changed");

    // a write either holds the position (star) or advances it by one
    a_write_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_wrote |->
            (i_out_pos == i_out_slot) || (i_out_pos == i_out_slot + 6'd1))
        else $error("write result with inconsistent position");

endmodule

bind escaped_byte_slot_packer_core esbp_checker u_esbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_slot  (o_result.slot_number),
    .i_out_value (o_result.slot_value),
    .i_out_wrote (o_result.wrote),
    .i_out_chan  (o_result.current_channel),
    .i_out_pos   (o_result.current_position),
    .i_out_esc   (o_result.escape_pending)
);
`default_nettype wire
